[rtl/cubic_bezier_easing_eval_unit_assert.svh]
// ----------------------------------------------------------------------------
// Cubic bezier easing assertion macros
// Concurrent check macros clocked by i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_EVAL_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_EASING_EVAL_UNIT_ASSERT_SVH

// hold cond on every active clock
`define CBE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("cbe check failed");

// same-cycle implication
`define CBE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbe check failed");

// next-cycle implication
`define CBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbe check failed");

`endif

[rtl/cbe_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic bezier easing package
// Widths, constants, codes and shared types of the easing evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 8;
    localparam int BISECT_STEPS = 20;

    localparam int CTRL_W  = 19;
    localparam int TOL_W   = 16;
    localparam int OUT_W   = 20;
    localparam int IDX_W   = 3;
    localparam int IN_TD_W  = 24;
    localparam int OUT_TD_W = 24;

    localparam int T_W   = FRAC_BITS + 1;
    localparam int B_W   = CTRL_W + 1;
    localparam int P_W   = T_W + 1 + B_W;
    localparam int R_W   = P_W - FRAC_BITS + 1;
    localparam int V_W   = 24;
    localparam int DVS_W = V_W - 1;
    localparam int DVD_W = DVS_W + FRAC_BITS;
    localparam int G_W   = DVD_W + 2;
    localparam int NC_W  = $clog2(NEWTON_STEPS + 1) + 1;
    localparam int BC_W  = $clog2(BISECT_STEPS + 1);
    localparam int DC_W  = $clog2(DVD_W + 1);

    localparam logic [T_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [V_W-1:0] OUT_MAX = V_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [V_W-1:0] OUT_MIN = -V_W'(1 << (OUT_W - 1));

    localparam logic signed [CTRL_W-1:0] RST_X1 = CTRL_W'(16384);
    localparam logic signed [CTRL_W-1:0] RST_Y1 = CTRL_W'(6554);
    localparam logic signed [CTRL_W-1:0] RST_X2 = CTRL_W'(16384);
    localparam logic signed [CTRL_W-1:0] RST_Y2 = CTRL_W'(65536);
    localparam logic [TOL_W-1:0]         RST_TOL = TOL_W'(4);

    typedef enum logic [IDX_W-1:0] {
        CFG_X1  = 3'd0,
        CFG_Y1  = 3'd1,
        CFG_X2  = 3'd2,
        CFG_Y2  = 3'd3,
        CFG_LIN = 3'd4,
        CFG_TOL = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_NEWTON,
        M_BISECT,
        M_FINAL
    } t_mode;

    typedef enum logic [3:0] {
        OP_UU,
        OP_TT,
        OP_UUT,
        OP_UTT,
        OP_TTT,
        OP_M1,
        OP_M2,
        OP_UT,
        OP_D1,
        OP_D2,
        OP_D3
    } t_op;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

[rtl/cbe_mul.sv]
// ----------------------------------------------------------------------------
// Cubic bezier easing shared multiplier
// Registered fixed-point product, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module cbe_mul (
    input  logic                                 i_clk,
    input  logic [cbe_pkg::T_W-1:0]              i_a,
    input  logic signed [cbe_pkg::B_W-1:0]       i_b,
    output logic signed [cbe_pkg::R_W-1:0]       o_res
);
    import cbe_pkg::*;

    logic signed [P_W-1:0]       r_prod;
    logic [P_W-1:0]              mag;
    logic [P_W-1:0]              rsum;
    logic [P_W-FRAC_BITS-1:0]    rmag;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_a}) * i_b;
    end

    always_comb begin
        mag   = r_prod[P_W-1] ? P_W'(-r_prod) : P_W'(r_prod);
        rsum  = mag + P_W'(1 << (FRAC_BITS - 1));
        rmag  = rsum[P_W-1:FRAC_BITS];
        o_res = r_prod[P_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    end

endmodule

[rtl/cbe_div.sv]
// ----------------------------------------------------------------------------
// Cubic bezier easing divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbe_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [cbe_pkg::DVD_W-1:0]     o_quo
);
    import cbe_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DC_W-1:0]   r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W+1:0]  diff;
    logic              take;

    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        take   = !diff[DVS_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DC_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], take};
            r_rem <= take ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/cubic_bezier_easing_eval_unit.sv]
// Linear mode or a clamped time of 0 or 1 is answered in the cycle after accept.
// A full solve runs Newton steps, each made of curve and slope products on the
// shared multiplier and a divide on the divider, then bisection steps of curve
// products only, then the final y evaluation.
// Throughput: one request at a time. Reset is synchronous, active low, and
// loads the default ease control points, tolerance 4, linear mode off.
// ----------------------------------------------------------------------------
// Cubic bezier easing evaluator
// Solves x(t) = time by Newton then bisection on one shared multiplier.
// ----------------------------------------------------------------------------
`include "cubic_bezier_easing_eval_unit_assert.svh"

module cubic_bezier_easing_eval_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cbe_pkg::IN_TD_W-1:0]        s_axis_tdata,   // [18:0] time_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cbe_pkg::OUT_TD_W-1:0]       m_axis_tdata,   // [19:0] eased_value
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbe_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [cbe_pkg::CTRL_W-1:0]         i_cfg_data
);
    import cbe_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode;
    t_op    r_op;
    logic   r_ph;
    logic [NC_W-1:0] r_ncnt;
    logic [BC_W-1:0] r_bcnt;

    logic signed [CTRL_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic                     r_lin;
    logic [TOL_W-1:0]         r_tol;

    logic [T_W-1:0] r_time, r_g, r_lo, r_hi;
    logic [T_W-1:0] r_uu, r_tt, r_uut, r_utt, r_ttt, r_ut;
    logic signed [R_W-1:0] r_m1, r_m2, r_d1, r_d2, r_d3;
    logic signed [OUT_W-1:0] r_res;
    logic r_qneg;

    logic signed [CTRL_W-1:0] tin;
    logic [T_W-1:0]  tc;
    logic            pass;
    logic            in_acc;
    logic [T_W-1:0]  u;
    logic signed [B_W-1:0] p1, p2;
    logic [T_W-1:0]  mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [R_W-1:0] mres;
    t_op             last_op;

    logic signed [V_W-1:0] m_sum, val, d_sum, dx, err, time_e;
    logic [V_W-1:0]  abs_err, abs_d;
    logic            err_ok, d_flat, b_gt;
    logic [T_W-1:0]  lo_n, hi_n, mid;
    logic [T_W:0]    lh_sum;
    logic signed [OUT_W-1:0] sat;

    t_div_req          div_req;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;
    logic signed [DVD_W:0] q_s;
    logic signed [G_W-1:0] g_wide;
    logic [T_W-1:0]    g_new;
    logic              n_last;
    logic              b_last;

    cbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mres)
    );

    cbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        tin = $signed(s_axis_tdata[CTRL_W-1:0]);
        if (tin < 0) begin
            tc = '0;
        end else if (tin > $signed({2'b00, FX_ONE})) begin
            tc = FX_ONE;
        end else begin
            tc = tin[T_W-1:0];
        end
        pass   = r_lin || (tc == '0) || (tc == FX_ONE);
        in_acc = s_axis_tvalid && s_axis_tready;
    end

    always_comb begin
        u       = FX_ONE - r_g;
        p1      = (r_mode == M_FINAL) ? $signed({r_y1[CTRL_W-1], r_y1})
                                      : $signed({r_x1[CTRL_W-1], r_x1});
        p2      = (r_mode == M_FINAL) ? $signed({r_y2[CTRL_W-1], r_y2})
                                      : $signed({r_x2[CTRL_W-1], r_x2});
        last_op = (r_mode == M_NEWTON) ? OP_D3 : OP_M2;
    end

    always_comb begin
        m_sum  = V_W'(r_m1) + V_W'(r_m2);
        val    = (m_sum <<< 1) + m_sum + $signed({{(V_W-T_W){1'b0}}, r_ttt});
        d_sum  = V_W'(r_d1) + (V_W'(r_d2) <<< 1) + V_W'(r_d3);
        dx     = (d_sum <<< 1) + d_sum;
        time_e = $signed({{(V_W-T_W){1'b0}}, r_time});
        err    = val - time_e;
        abs_err = err[V_W-1] ? V_W'(-err) : V_W'(err);
        abs_d   = dx[V_W-1] ? V_W'(-dx) : V_W'(dx);
        err_ok  = abs_err < {{(V_W-TOL_W){1'b0}}, r_tol};
        d_flat  = (abs_d < {{(V_W-TOL_W){1'b0}}, r_tol}) || (dx == '0);
        b_gt    = time_e > val;
        lo_n    = b_gt ? r_g : r_lo;
        hi_n    = b_gt ? r_hi : r_g;
        lh_sum  = {1'b0, lo_n} + {1'b0, hi_n};
        mid     = lh_sum[T_W:1];
        b_last  = (r_bcnt + 1'b1) == BC_W'(BISECT_STEPS);
        if (val > OUT_MAX) begin
            sat = OUT_MAX[OUT_W-1:0];
        end else if (val < OUT_MIN) begin
            sat = OUT_MIN[OUT_W-1:0];
        end else begin
            sat = val[OUT_W-1:0];
        end
    end

    always_comb begin
        q_s    = r_qneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        g_wide = $signed({{(G_W-T_W){1'b0}}, r_g}) - G_W'(q_s);
        if (g_wide < 0) begin
            g_new = '0;
        end else if (g_wide > $signed({{(G_W-T_W){1'b0}}, FX_ONE})) begin
            g_new = FX_ONE;
        end else begin
            g_new = g_wide[T_W-1:0];
        end
        n_last = (r_ncnt + 1'b1) == NC_W'(NEWTON_STEPS);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = pass ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                if (r_ph && (r_op == last_op)) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_mode == M_FINAL) begin
                    n_state = S_DONE;
                end else if ((r_mode == M_NEWTON) && !err_ok && !d_flat) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_EVAL;
            end
            S_DONE: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = (r_state == S_IDLE);
        m_axis_tvalid    = (r_state == S_DONE);
        m_axis_tdata     = {{(OUT_TD_W-OUT_W){1'b0}}, r_res};
        o_cfg_ready      = 1'b1;
        div_req.start    = (r_state == S_CHECK) && (r_mode == M_NEWTON) && !err_ok && !d_flat;
        div_req.dividend = {abs_err[DVS_W-1:0], {FRAC_BITS{1'b0}}};
        div_req.divisor  = abs_d[DVS_W-1:0];
        mul_a = u;
        mul_b = $signed({{(B_W-T_W){1'b0}}, u});
        case (r_op)
            OP_UU: begin
                mul_a = u;
                mul_b = $signed({{(B_W-T_W){1'b0}}, u});
            end
            OP_TT: begin
                mul_a = r_g;
                mul_b = $signed({{(B_W-T_W){1'b0}}, r_g});
            end
            OP_UUT: begin
                mul_a = r_uu;
                mul_b = $signed({{(B_W-T_W){1'b0}}, r_g});
            end
            OP_UTT: begin
                mul_a = u;
                mul_b = $signed({{(B_W-T_W){1'b0}}, r_tt});
            end
            OP_TTT: begin
                mul_a = r_tt;
                mul_b = $signed({{(B_W-T_W){1'b0}}, r_g});
            end
            OP_M1: begin
                mul_a = r_uut;
                mul_b = p1;
            end
            OP_M2: begin
                mul_a = r_utt;
                mul_b = p2;
            end
            OP_UT: begin
                mul_a = u;
                mul_b = $signed({{(B_W-T_W){1'b0}}, r_g});
            end
            OP_D1: begin
                mul_a = r_uu;
                mul_b = p1;
            end
            OP_D2: begin
                mul_a = r_ut;
                mul_b = p2 - p1;
            end
            OP_D3: begin
                mul_a = r_tt;
                mul_b = $signed({{(B_W-T_W){1'b0}}, FX_ONE}) - p2;
            end
            default: begin
                mul_a = u;
                mul_b = $signed({{(B_W-T_W){1'b0}}, u});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_NEWTON;
            r_op    <= OP_UU;
            r_ph    <= 1'b0;
            r_ncnt  <= '0;
            r_bcnt  <= '0;
            r_x1    <= RST_X1;
            r_y1    <= RST_Y1;
            r_x2    <= RST_X2;
            r_y2    <= RST_Y2;
            r_lin   <= 1'b0;
            r_tol   <= RST_TOL;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X1:  r_x1  <= i_cfg_data;
                    CFG_Y1:  r_y1  <= i_cfg_data;
                    CFG_X2:  r_x2  <= i_cfg_data;
                    CFG_Y2:  r_y2  <= i_cfg_data;
                    CFG_LIN: r_lin <= i_cfg_data[0];
                    CFG_TOL: r_tol <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode <= (NEWTON_STEPS == 0) ? M_BISECT : M_NEWTON;
                        r_op   <= OP_UU;
                        r_ph   <= 1'b0;
                        r_ncnt <= '0;
                        r_bcnt <= '0;
                    end
                end
                S_EVAL: begin
                    r_ph <= !r_ph;
                    if (r_ph) r_op <= (r_op == last_op) ? OP_UU : t_op'(r_op + 1'b1);
                end
                S_CHECK: begin
                    if (r_mode == M_NEWTON) begin
                        if (err_ok) begin
                            r_mode <= M_FINAL;
                        end else if (d_flat) begin
                            r_mode <= M_BISECT;
                        end
                    end else if (r_mode == M_BISECT) begin
                        r_bcnt <= r_bcnt + 1'b1;
                        if (err_ok || b_last) r_mode <= M_FINAL;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ncnt <= r_ncnt + 1'b1;
                        if (n_last) r_mode <= M_BISECT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_time <= tc;
                    r_g    <= tc;
                    r_lo   <= '0;
                    r_hi   <= FX_ONE;
                    r_res  <= $signed({{(OUT_W-T_W){1'b0}}, tc});
                end
            end
            S_EVAL: begin
                if (r_ph) begin
                    case (r_op)
                        OP_UU:   r_uu  <= mres[T_W-1:0];
                        OP_TT:   r_tt  <= mres[T_W-1:0];
                        OP_UUT:  r_uut <= mres[T_W-1:0];
                        OP_UTT:  r_utt <= mres[T_W-1:0];
                        OP_TTT:  r_ttt <= mres[T_W-1:0];
                        OP_M1:   r_m1  <= mres;
                        OP_M2:   r_m2  <= mres;
                        OP_UT:   r_ut  <= mres[T_W-1:0];
                        OP_D1:   r_d1  <= mres;
                        OP_D2:   r_d2  <= mres;
                        OP_D3:   r_d3  <= mres;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                case (r_mode)
                    M_NEWTON: begin
                        r_qneg <= err[V_W-1] ^ dx[V_W-1];
                        if (!err_ok && d_flat) begin
                            r_g  <= r_time;
                            r_lo <= '0;
                            r_hi <= FX_ONE;
                        end
                    end
                    M_BISECT: begin
                        if (!err_ok) begin
                            r_lo <= lo_n;
                            r_hi <= hi_n;
                            r_g  <= mid;
                        end
                    end
                    M_FINAL: r_res <= sat;
                    default: ;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    if (n_last) begin
                        r_g  <= r_time;
                        r_lo <= '0;
                        r_hi <= FX_ONE;
                    end else begin
                        r_g <= g_new;
                    end
                end
            end
            default: ;
        endcase
    end

    `CBE_ASSERT_IMPL(a_g_in_range, r_state != S_IDLE, r_g <= FX_ONE)
    `CBE_ASSERT_IMPL(a_div_nonzero, div_req.start, div_req.divisor != '0)
    `CBE_ASSERT_IMPL(a_div_in_newton, r_state == S_DIV, r_mode == M_NEWTON)
    `CBE_ASSERT_IMPL(a_bisect_order, r_mode == M_BISECT && r_state != S_IDLE, r_lo <= r_hi)
    `CBE_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, r_state != S_IDLE)

endmodule
